[rtl/rsm_pkg.sv]
// ----------------------------------------------------------------------------
// rsm_pkg: shared types, constants and helpers for the row softmax block
// Holds the 2^-f table, the controller command and status structs.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int MaxRow = 64;
  localparam int IdxW = $clog2(MaxRow);
  localparam int CntW = IdxW + 1;
  localparam int SumW = 23;
  localparam int ExpW = 17;
  localparam logic [15:0] Log2eQ15 = 16'd47274;

  localparam logic [6:0] RegRowLength = 7'd0;
  localparam logic [6:0] RowLengthReset = 7'd16;

  typedef struct packed {
    logic store_wr;     // write sample into the row store and update max
    logic clear_fill;   // start of a new row
    logic clear_sum;
    logic rd_en;        // issue a store read at rd_addr
    logic [IdxW-1:0] rd_addr;
    logic exp_s1;       // exponent stage 1 valid (store data present)
    logic exp_s2;       // exponent stage 2 valid
    logic exp_s3;       // exponent stage 3 valid: accumulate
    logic div_start;    // start a division for the current stored exponent
    logic [IdxW-1:0] ev_idx;
  } rsm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } rsm_sts_t;

  function automatic logic [16:0] pow2_tab(input logic [6:0] i);
    logic [16:0] r;
    case (i)
      7'd0: r = 17'd65536;  7'd1: r = 17'd64830;  7'd2: r = 17'd64132;
      7'd3: r = 17'd63441;  7'd4: r = 17'd62757;  7'd5: r = 17'd62081;
      7'd6: r = 17'd61413;  7'd7: r = 17'd60751;  7'd8: r = 17'd60097;
      7'd9: r = 17'd59449;  7'd10: r = 17'd58809; 7'd11: r = 17'd58176;
      7'd12: r = 17'd57549; 7'd13: r = 17'd56929; 7'd14: r = 17'd56316;
      7'd15: r = 17'd55709; 7'd16: r = 17'd55109; 7'd17: r = 17'd54515;
      7'd18: r = 17'd53928; 7'd19: r = 17'd53347; 7'd20: r = 17'd52773;
      7'd21: r = 17'd52204; 7'd22: r = 17'd51642; 7'd23: r = 17'd51085;
      7'd24: r = 17'd50535; 7'd25: r = 17'd49991; 7'd26: r = 17'd49452;
      7'd27: r = 17'd48920; 7'd28: r = 17'd48393; 7'd29: r = 17'd47871;
      7'd30: r = 17'd47356; 7'd31: r = 17'd46846; 7'd32: r = 17'd46341;
      7'd33: r = 17'd45842; 7'd34: r = 17'd45348; 7'd35: r = 17'd44859;
      7'd36: r = 17'd44376; 7'd37: r = 17'd43898; 7'd38: r = 17'd43425;
      7'd39: r = 17'd42958; 7'd40: r = 17'd42495; 7'd41: r = 17'd42037;
      7'd42: r = 17'd41584; 7'd43: r = 17'd41136; 7'd44: r = 17'd40693;
      7'd45: r = 17'd40255; 7'd46: r = 17'd39821; 7'd47: r = 17'd39392;
      7'd48: r = 17'd38968; 7'd49: r = 17'd38548; 7'd50: r = 17'd38133;
      7'd51: r = 17'd37722; 7'd52: r = 17'd37316; 7'd53: r = 17'd36914;
      7'd54: r = 17'd36516; 7'd55: r = 17'd36123; 7'd56: r = 17'd35734;
      7'd57: r = 17'd35349; 7'd58: r = 17'd34968; 7'd59: r = 17'd34591;
      7'd60: r = 17'd34219; 7'd61: r = 17'd33850; 7'd62: r = 17'd33486;
      7'd63: r = 17'd33125; 7'd64: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/rsm_ram.sv]
// ----------------------------------------------------------------------------
// rsm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rsm_div.sv]
// ----------------------------------------------------------------------------
// rsm_div: restoring divider for the probability quotient
// Computes (num + den/2) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsm_pkg::ExpW-1:0]  ev_i,
  input  logic [rsm_pkg::SumW-1:0]  den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [15:0]               quot_o
);
  import rsm_pkg::*;

  // Numerator is ev<<16 plus den>>1, at most 2^33 + 2^22: 34 bits.
  localparam int NumW = 34;
  localparam int QW = 18;

  logic [NumW-1:0] num_q, num_d;
  logic [SumW:0]   rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SumW:0]   trial;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i && !busy_q) begin
      num_d = {ev_i, 16'd0} + NumW'(den_i >> 1);
      rem_d = '0;
      quo_d = '0;
      cnt_d = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[SumW-1:0], num_q[NumW-1]};
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Quotient only ever overflows 16 bits by saturation; zero sum gives zero.
  assign quot_o = (den_i == '0) ? 16'd0 :
                  (quo_q[QW-1:16] != '0) ? 16'hFFFF : quo_q[15:0];
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[rtl/rsm_datapath.sv]
// ----------------------------------------------------------------------------
// rsm_datapath: row store, running max, exponent pipeline and normalizer
// Executes the controller's commands; the exponent pipeline has three stages.
// ----------------------------------------------------------------------------
module rsm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsm_pkg::rsm_cmd_t             cmd_i,
  output rsm_pkg::rsm_sts_t             sts_o,
  input  logic [15:0]                   sample_i,
  input  logic [rsm_pkg::IdxW-1:0]      wr_addr_i,
  output logic [15:0]                   quot_o
);
  import rsm_pkg::*;

  logic [15:0]    max_q;
  logic [15:0]    rd_data;
  logic [SumW-1:0] sum_q;
  logic [ExpW-1:0] ev_rd;
  logic [15:0]    d;
  logic [32:0]    prod_q;
  logic [4:0]     ip_s2_q;
  logic [5:0]     idx_s2_q;
  logic [9:0]     w_s2_q;
  logic [IdxW-1:0] a_s1_q, a_s2_q, a_s3_q;
  logic [16:0]    t0, t1;
  logic [27:0]    mulw;
  logic [16:0]    v;
  logic [ExpW-1:0] e_s3;
  logic           flush_s2_q;
  logic [32:0]    t16;
  logic           sw_newmax;

  rsm_ram #(.Width(16), .Depth(MaxRow)) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store_wr),
    .waddr_i(wr_addr_i),
    .wdata_i(sample_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rd_data)
  );

  assign sw_newmax = $signed(sample_i) > $signed(max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      sum_q <= '0;
    end else begin
      if (cmd_i.store_wr && (cmd_i.clear_fill || sw_newmax)) begin
        max_q <= sample_i;
      end
      if (cmd_i.clear_sum) begin
        sum_q <= '0;
      end else if (cmd_i.exp_s3) begin
        sum_q <= sum_q + SumW'(e_s3);
      end
    end
  end

  // Stage 1: difference from max times log2(e).
  assign d = max_q - rd_data;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      a_s1_q <= cmd_i.rd_addr;
    end
    if (cmd_i.exp_s1) begin
      prod_q <= {1'b0, d} * {1'b0, Log2eQ15};
      a_s2_q <= a_s1_q;
    end
  end

  // Stage 2: split into integer part, table index and weight. Integer
  // parts of 17 and above fall under 2^-16 and flush to zero.
  assign t16 = (prod_q + 33'd64) >> 7;
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_s2) begin
      flush_s2_q <= (t16[32:16] >= 17'd17);
      ip_s2_q  <= t16[20:16];
      idx_s2_q <= t16[15:10];
      w_s2_q   <= t16[9:0];
      a_s3_q   <= a_s2_q;
    end
  end

  // Stage 3: interpolate and shift.
  assign t0 = pow2_tab({1'b0, idx_s2_q});
  assign t1 = pow2_tab({1'b0, idx_s2_q} + 7'd1);
  assign mulw = 28'(t0 - t1) * 28'(w_s2_q) + 28'd512;
  assign v = t0 - 17'(mulw >> 10);
  assign e_s3 = flush_s2_q ? '0 : (v >> ip_s2_q);

  rsm_ram #(.Width(ExpW), .Depth(MaxRow)) u_ev (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exp_s3),
    .waddr_i(a_s3_q),
    .wdata_i(e_s3),
    .re_i   (1'b1),
    .raddr_i(cmd_i.ev_idx),
    .rdata_o(ev_rd)
  );

  rsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .ev_i   (ev_rd),
    .den_i  (sum_q),
    .busy_o (sts_o.div_busy),
    .done_o (sts_o.div_done),
    .quot_o (quot_o)
  );

endmodule

[rtl/rsm_ctrl.sv]
// ----------------------------------------------------------------------------
// rsm_ctrl: row softmax sequencer
// Loads samples, sweeps the row through the exponent pipe, then divides.
// ----------------------------------------------------------------------------
module rsm_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     row_end_o,
  input  logic [6:0]               row_length_i,
  output rsm_pkg::rsm_cmd_t        cmd_o,
  input  rsm_pkg::rsm_sts_t        sts_i,
  output logic [rsm_pkg::IdxW-1:0] wr_addr_o
);
  import rsm_pkg::*;

  typedef enum logic [3:0] {
    StLoad = 4'b0001,
    StExp  = 4'b0010,
    StDiv  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d, cnt_q, cnt_d, rd_q, rd_d, ex_q, ex_d;
  logic [CntW-1:0] eff_len, fill_now;
  logic [2:0]      pipe_q, pipe_d;
  logic            accept, out_acc;

  assign eff_len = (row_length_i == 7'd0) ? CntW'(1) :
                   (row_length_i > 7'(MaxRow)) ? CntW'(MaxRow) : CntW'(row_length_i);
  assign fill_now = (fill_q >= CntW'(MaxRow)) ? '0 : fill_q;
  assign accept = in_valid_i && (state_q == StLoad);
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != StLoad);
  assign out_valid_o = (state_q == StOut);
  assign row_end_o = (ex_q + CntW'(1) == cnt_q);
  assign wr_addr_o = fill_now[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    cnt_d = cnt_q;
    rd_d = rd_q;
    ex_d = ex_q;
    pipe_d = {pipe_q[1:0], 1'b0};
    cmd_o = '0;
    cmd_o.rd_addr = rd_q[IdxW-1:0];
    cmd_o.exp_s1 = pipe_q[0];
    cmd_o.exp_s2 = pipe_q[1];
    cmd_o.exp_s3 = pipe_q[2];
    case (state_q)
      StLoad: begin
        if (accept) begin
          cmd_o.store_wr = 1'b1;
          cmd_o.clear_fill = (fill_now == '0);
          fill_d = fill_now + CntW'(1);
          if (fill_now + CntW'(1) >= eff_len) begin
            cnt_d = fill_now + CntW'(1);
            fill_d = '0;
            rd_d = '0;
            cmd_o.clear_sum = 1'b1;
            state_d = StExp;
          end
        end
      end
      StExp: begin
        if (rd_q < cnt_q) begin
          cmd_o.rd_en = 1'b1;
          pipe_d[0] = 1'b1;
          rd_d = rd_q + CntW'(1);
        end else if (pipe_q == '0) begin
          ex_d = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_start = !sts_i.div_busy && !sts_i.div_done;
        if (sts_i.div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_acc) begin
          ex_d = ex_q + CntW'(1);
          state_d = row_end_o ? StLoad : StDiv;
        end
      end
      default: state_d = StLoad;
    endcase
    // The exponent store has a registered read, so it is addressed with
    // the next element index, ex_d, rather than ex_q.
    cmd_o.ev_idx = ex_d[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      fill_q <= '0;
      cnt_q <= '0;
      rd_q <= '0;
      ex_q <= '0;
      pipe_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      cnt_q <= cnt_d;
      rd_q <= rd_d;
      ex_q <= ex_d;
      pipe_q <= pipe_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !cmd_o.store_wr) else $error("write outside load");
  a_ex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (ex_q < cnt_q)) else $error("output index past row");
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (rd_q < cnt_q)) else $error("read past row");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
`endif

endmodule

[rtl/row_softmax.sv]
// ----------------------------------------------------------------------------
// row_softmax: numerically stable softmax over rows of Q8.8 samples
// Top level with the register port, controller and datapath.
// ----------------------------------------------------------------------------
// Samples enter on sample_i with in_valid_i/in_stall_o, one per cycle while
// a row loads; a request completes when valid is high and stall is low.
// When the row_length-th sample lands (row_length taken as 1 for 0 and as
// 64 above 64), the block stalls its input, sweeps the row through a
// three-stage exponent pipe, one element per cycle, then emits one
// probability per element through a restoring divider, one division at
// a time. A whole row is loaded, swept and divided before the input opens
// again. row_end_o marks the last result of a row.
// out_valid_o holds with its payload while out_stall_i is high, and the
// next division waits for it. Reset clears the row count, the maximum and
// the sum, and sets row_length to 16 at byte address 0 of the APB port.
// Change row_length only while no row is in progress.
// ----------------------------------------------------------------------------
module row_softmax (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] probability_o,
  output logic        row_end_o
);
  import rsm_pkg::*;

  logic [6:0]       row_length_q;
  rsm_cmd_t         cmd;
  rsm_sts_t         sts;
  logic [IdxW-1:0]  wr_addr;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RowLengthReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      row_length_q <= pwdata[6:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, row_length_q} : 32'd0;

  rsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_end_o   (row_end_o),
    .row_length_i(row_length_q),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .wr_addr_o   (wr_addr)
  );

  rsm_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .sample_i (sample_i),
    .wr_addr_i(wr_addr),
    .quot_o   (probability_o)
  );

endmodule
